// ===== hw/rtl/fem_pkg.sv =====
// shared types, register codes and shape constants for the face element mass matrix
package fem_pkg;

  // input item: one boundary face element
  typedef struct packed {
    logic [2:0]         face;
    logic [4:0]         level;
    logic signed [31:0] coef0;
    logic signed [31:0] coef1;
    logic signed [31:0] coef2;
    logic signed [31:0] coef3;
    logic signed [31:0] load0;
    logic signed [31:0] load1;
    logic signed [31:0] load2;
    logic signed [31:0] load3;
  } in_data_t;

  // result item: one matrix or load entry
  typedef struct packed {
    logic               kind;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [63:0] value;
    logic               last;
  } out_data_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_EDGE_X    = 3'd0,
    REG_EDGE_Y    = 3'd1,
    REG_EDGE_Z    = 3'd2,
    REG_COEF_PP   = 3'd3,
    REG_LOAD_PP   = 3'd4,
    REG_REDUCED   = 3'd5,
    REG_MAT_EN    = 3'd6,
    REG_VEC_EN    = 3'd7
  } reg_idx_t;

  // shape products at the gauss points, Q0.40
  localparam logic [63:0] Q40_CHI2 = 64'd683905543062;
  localparam logic [63:0] Q40_MIX  = 64'd183251937963;
  localparam logic [63:0] Q40_CLO2 = 64'd49102208789;

  // bilinear shape value of a node at a gauss point, rounded to frac bits
  function automatic logic [63:0] shape_val(input logic [1:0] node, input logic [1:0] pt,
                                            input int frac);
    logic [1:0]  hits;
    logic [63:0] c;
    hits = {1'b0, ~(node[0] ^ pt[0])} + {1'b0, ~(node[1] ^ pt[1])};
    c = (hits == 2'd2) ? Q40_CHI2 : ((hits == 2'd1) ? Q40_MIX : Q40_CLO2);
    return (c + (64'd1 << (39 - frac))) >> (40 - frac);
  endfunction

  // matrix weight for a node pair at a gauss point, rounded to frac bits
  function automatic logic [63:0] wt_val(input logic [1:0] a, input logic [1:0] b,
                                         input logic [1:0] g, input int frac);
    logic [63:0] prod;
    prod = shape_val(a, g, frac) * shape_val(b, g, frac);
    return (prod + (64'd1 << (frac - 1))) >> frac;
  endfunction

endpackage

// ===== hw/rtl/face_element_mass_matrix.sv =====
// face element mass matrix and load vector, deep pipeline with entry sequencer
//
//  channel | ports                               | moves
//  --------+-------------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data         | one face element per transfer
//  out     | out_valid, out_ready, out_data      | one matrix/load entry per transfer
//  cfg     | psel penable pwrite paddr pwdata .. | register writes and reads
//
// an element holds the entry sequencer for its 20 entries (16 with only the matrix, 4 with
// only the vector, none with neither); the sequencer issues one entry a cycle while the
// output does not stall, into a 6-stage pipeline, so the next element is taken in the cycle
// the last entry is issued. reset clears the valid bits and sets the config registers to
// defaults. a stalled output freezes every stage at once; nothing is lost or repeated.
module face_element_mass_matrix
  import fem_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int MAX_LEVEL = 19
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_data_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_data_t   out_data
);

  localparam int WTW  = FRAC_BITS + 1;
  localparam int PW   = 32 + WTW + 1;
  localparam int SUMW = PW + 2;
  localparam int SW   = SUMW - FRAC_BITS;
  localparam int MW   = SW + 33;
  localparam int FW   = SW + 66;

  // configuration registers
  logic [31:0] edge_x_r, edge_y_r, edge_z_r;
  logic        coef_pp_r, load_pp_r, reduced_r, mat_en_r, vec_en_r;
  reg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_x_r  <= 32'h0001_0000;
      edge_y_r  <= 32'h0001_0000;
      edge_z_r  <= 32'h0001_0000;
      coef_pp_r <= 1'b1;
      load_pp_r <= 1'b1;
      reduced_r <= 1'b0;
      mat_en_r  <= 1'b1;
      vec_en_r  <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        REG_EDGE_X:  edge_x_r  <= pwdata;
        REG_EDGE_Y:  edge_y_r  <= pwdata;
        REG_EDGE_Z:  edge_z_r  <= pwdata;
        REG_COEF_PP: coef_pp_r <= pwdata[0];
        REG_LOAD_PP: load_pp_r <= pwdata[0];
        REG_REDUCED: reduced_r <= pwdata[0];
        REG_MAT_EN:  mat_en_r  <= pwdata[0];
        REG_VEC_EN:  vec_en_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_EDGE_X:  prdata = edge_x_r;
      REG_EDGE_Y:  prdata = edge_y_r;
      REG_EDGE_Z:  prdata = edge_z_r;
      REG_COEF_PP: prdata = {31'd0, coef_pp_r};
      REG_LOAD_PP: prdata = {31'd0, load_pp_r};
      REG_REDUCED: prdata = {31'd0, reduced_r};
      REG_MAT_EN:  prdata = {31'd0, mat_en_r};
      REG_VEC_EN:  prdata = {31'd0, vec_en_r};
      default:     prdata = 32'd0;
    endcase
  end

  // whole pipeline moves when the output register is free or its entry is taken
  logic adv;
  assign adv = !out_valid || out_ready;

  // element holding register and sequencer
  logic               elem_valid_r;
  logic [4:0]         idx_r, idx_nxt;
  in_data_t           elem_r;
  logic [63:0]        area_r;
  logic [6:0]         sh_r;
  logic               issue, is_last, take;
  logic [31:0]        e1, e2;
  logic [4:0]         lvl;

  assign issue   = elem_valid_r && adv;
  assign is_last = (idx_r == 5'd19) || (idx_r == 5'd15 && !vec_en_r);
  assign in_ready = !elem_valid_r || (issue && is_last);
  assign take    = in_valid && in_ready;

  // face picks the in-plane edges, level is clamped
  always_comb begin
    if (in_data.face < 3'd2) begin
      e1 = edge_y_r; e2 = edge_z_r;
    end else if (in_data.face < 3'd4) begin
      e1 = edge_x_r; e2 = edge_z_r;
    end else begin
      e1 = edge_x_r; e2 = edge_y_r;
    end
    lvl = (in_data.level > 5'(MAX_LEVEL)) ? 5'(MAX_LEVEL) : in_data.level;
    idx_nxt = mat_en_r ? 5'd0 : 5'd16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_valid_r <= 1'b0;
      idx_r        <= 5'd0;
    end else if (take) begin
      elem_valid_r <= mat_en_r || vec_en_r;
      idx_r        <= idx_nxt;
    end else if (issue) begin
      if (is_last) elem_valid_r <= 1'b0;
      idx_r <= (idx_r == 5'd15) ? 5'd16 : idx_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      elem_r <= in_data;
      area_r <= {32'd0, e1} * {32'd0, e2};
      sh_r   <= 7'd18 + {1'b0, lvl, 1'b0};
    end
  end

  // stage 0: operand selection for one entry
  logic                  kind0;
  logic [1:0]            row0, col0;
  logic signed [31:0]    cf0 [4];
  logic [WTW-1:0]        wt0 [4];
  logic signed [31:0]    ld_sel [4];
  logic signed [31:0]    cf_sel [4];

  assign kind0 = idx_r[4];
  assign row0  = kind0 ? idx_r[1:0] : idx_r[3:2];
  assign col0  = kind0 ? 2'd0 : idx_r[1:0];

  always_comb begin
    cf_sel[0] = elem_r.coef0;
    cf_sel[1] = coef_pp_r ? elem_r.coef1 : elem_r.coef0;
    cf_sel[2] = coef_pp_r ? elem_r.coef2 : elem_r.coef0;
    cf_sel[3] = coef_pp_r ? elem_r.coef3 : elem_r.coef0;
    ld_sel[0] = elem_r.load0;
    ld_sel[1] = load_pp_r ? elem_r.load1 : elem_r.load0;
    ld_sel[2] = load_pp_r ? elem_r.load2 : elem_r.load0;
    ld_sel[3] = load_pp_r ? elem_r.load3 : elem_r.load0;
    for (int g = 0; g < 4; g++) begin
      cf0[g] = kind0 ? ld_sel[g] : cf_sel[g];
      wt0[g] = kind0 ? WTW'(shape_val(row0, 2'(g), FRAC_BITS))
                     : WTW'(wt_val(row0, col0, 2'(g), FRAC_BITS));
    end
  end

  logic                v1_r, kind1_r, last1_r, red1_r;
  logic [1:0]          row1_r, col1_r;
  logic signed [31:0]  cf1_r [4];
  logic [WTW-1:0]      wt1_r [4];
  logic signed [31:0]  op1_r;
  logic [63:0]         area1_r;
  logic [6:0]          sh1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= issue;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1_r <= kind0;
      row1_r  <= row0;
      col1_r  <= col0;
      last1_r <= is_last;
      red1_r  <= reduced_r;
      cf1_r   <= cf0;
      wt1_r   <= wt0;
      op1_r   <= kind0 ? elem_r.load0 : elem_r.coef0;
      area1_r <= area_r;
      sh1_r   <= sh_r + ((reduced_r && !kind0) ? 7'd2 : 7'd0);
    end
  end

  // stage 1: four point products
  logic                v2_r, kind2_r, last2_r, red2_r;
  logic [1:0]          row2_r, col2_r;
  logic signed [PW-1:0] pr2_r [4];
  logic signed [31:0]  op2_r;
  logic [63:0]         area2_r;
  logic [6:0]          sh2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < 4; g++) begin
        pr2_r[g] <= PW'(cf1_r[g]) * $signed({1'b0, wt1_r[g]});
      end
      kind2_r <= kind1_r; row2_r <= row1_r; col2_r <= col1_r; last2_r <= last1_r;
      red2_r  <= red1_r;  op2_r  <= op1_r;  area2_r <= area1_r; sh2_r <= sh1_r;
    end
  end

  // stage 2: sum and round to Q16.16, or pass the first coefficient or load when reduced
  logic signed [SUMW-1:0] sum2;
  logic signed [SUMW-1:0] rnd2;
  assign sum2 = SUMW'(pr2_r[0]) + SUMW'(pr2_r[1]) + SUMW'(pr2_r[2]) + SUMW'(pr2_r[3]);
  assign rnd2 = (sum2 + (SUMW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

  logic                v3_r, kind3_r, last3_r;
  logic [1:0]          row3_r, col3_r;
  logic signed [SW-1:0] s3_r;
  logic [63:0]         area3_r;
  logic [6:0]          sh3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_r    <= red2_r ? SW'(op2_r) : rnd2[SW-1:0];
      kind3_r <= kind2_r; row3_r <= row2_r; col3_r <= col2_r; last3_r <= last2_r;
      area3_r <= area2_r; sh3_r <= sh2_r;
    end
  end

  // stage 3: area product in two halves
  logic                v4_r, kind4_r, last4_r;
  logic [1:0]          row4_r, col4_r;
  logic signed [MW-1:0] mlo4_r, mhi4_r;
  logic [6:0]          sh4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mlo4_r  <= MW'(s3_r) * $signed({1'b0, area3_r[31:0]});
      mhi4_r  <= MW'(s3_r) * $signed({1'b0, area3_r[63:32]});
      kind4_r <= kind3_r; row4_r <= row3_r; col4_r <= col3_r; last4_r <= last3_r;
      sh4_r   <= sh3_r;
    end
  end

  // stage 4: combine halves and add rounding half
  logic                v5_r, kind5_r, last5_r;
  logic [1:0]          row5_r, col5_r;
  logic signed [FW-1:0] full5_r;
  logic [6:0]          sh5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (adv) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      full5_r <= (FW'(mhi4_r) <<< 32) + FW'(mlo4_r) + (FW'(1) <<< (sh4_r - 7'd1));
      kind5_r <= kind4_r; row5_r <= row4_r; col5_r <= col4_r; last5_r <= last4_r;
      sh5_r   <= sh4_r;
    end
  end

  // stage 5: shift and saturate into the output register
  logic signed [FW-1:0] shd5;
  logic signed [63:0]   sat5;
  logic                 ovf5;
  assign shd5 = full5_r >>> sh5_r;
  assign ovf5 = !((&shd5[FW-1:63]) || !(|shd5[FW-1:63]));
  assign sat5 = ovf5 ? (shd5[FW-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : shd5[63:0];

  logic v6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (adv) v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.kind  <= kind5_r;
      out_data.row   <= row5_r;
      out_data.col   <= col5_r;
      out_data.value <= sat5;
      out_data.last  <= last5_r;
    end
  end

  assign out_valid = v6_r;

  // no new element while the current one still has entries to issue
  a_hold_elem: assert property (@(posedge clk) disable iff (!rst_n)
    elem_valid_r && !(issue && is_last) |-> !in_ready)
    else $error("element taken before last entry issued");

  // sequencer index stays within the entry list
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    elem_valid_r |-> idx_r <= 5'd19)
    else $error("entry index out of range");

  // load entries always carry column zero
  a_load_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind |-> out_data.col == 2'd0)
    else $error("load entry with nonzero column");

  // a stall freezes the stage 4 result register
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v5_r) && $stable(full5_r))
    else $error("pipeline moved during stall");

endmodule

// ===== bench/face_element_mass_matrix_tb.sv =====
// self-checking testbench for the face element mass matrix block
module face_element_mass_matrix_tb
  import fem_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FRAC      = 16;
  localparam int  LEVEL_CAP = 19;
  localparam int  NUM_PHASES = 10;
  localparam int  NUM_ROWS = 11;
  localparam int  PHASE_ITEMS = 30;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam logic KIND_MAT  = 1'b0;
  localparam logic KIND_LOAD = 1'b1;
  localparam logic signed [129:0] SAT_MAX = 130'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [129:0] SAT_MIN = -SAT_MAX - 130'sd1;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_data_t    in_data;
  out_data_t   out_data;

  face_element_mass_matrix dut (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  // register copy used for prediction
  logic [31:0] len_x, len_y, len_z;
  logic        coef_pp, load_pp, centre_rule, mat_on, vec_on;

  out_data_t entries_due[$];
  int        fail_count;
  int        cycle_count;
  bit        rx_no_stall;

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // bilinear shape value at a gauss point, rounded to frac bits
  function automatic logic [63:0] shape_q(input int node, input int pt);
    int          hits;
    logic [63:0] c;
    hits = ((((node ^ pt) & 1) == 0) ? 1 : 0) + ((((node ^ pt) & 2) == 0) ? 1 : 0);
    c = (hits == 2) ? 64'd683905543062 : ((hits == 1) ? 64'd183251937963 : 64'd49102208789);
    return (c + (64'd1 << (39 - FRAC))) >> (40 - FRAC);
  endfunction

  // round half up and arithmetic shift right
  function automatic logic signed [129:0] round_shift(input logic signed [129:0] v,
                                                      input int n);
    logic signed [129:0] one;
    one = 130'sd1;
    return (v + (one <<< (n - 1))) >>> n;
  endfunction

  // scale a q16.16 value by the face area product, saturate to 64 bits
  function automatic logic signed [63:0] area_scale(input logic signed [63:0] x,
                                                    input logic [63:0] prod, input int sh);
    logic signed [129:0] xs, ps, r;
    xs = x;
    ps = {66'd0, prod};
    r = round_shift(xs * ps, sh);
    if (r > SAT_MAX) return SAT_MAX[63:0];
    if (r < SAT_MIN) return SAT_MIN[63:0];
    return r[63:0];
  endfunction

  // expected matrix and load entries of one face element
  task automatic face_entries(input in_data_t d);
    logic signed [31:0]  cf[4], ld[4], cin[4], lin[4];
    logic [63:0]         e1, e2, prod, w;
    logic signed [129:0] acc, wt;
    logic signed [63:0]  s;
    int                  lv, sh, first;
    out_data_t           e;
    cin = '{d.coef0, d.coef1, d.coef2, d.coef3};
    lin = '{d.load0, d.load1, d.load2, d.load3};
    lv = (d.level > LEVEL_CAP) ? LEVEL_CAP : int'(d.level);
    sh = 18 + 2 * lv;
    for (int g = 0; g < 4; g++) begin
      cf[g] = coef_pp ? cin[g] : cin[0];
      ld[g] = load_pp ? lin[g] : lin[0];
    end
    // faces 6 and 7 fall back to the x-y plane
    if (d.face < 2) begin
      e1 = len_y; e2 = len_z;
    end else if (d.face < 4) begin
      e1 = len_x; e2 = len_z;
    end else begin
      e1 = len_x; e2 = len_y;
    end
    prod = e1 * e2;
    first = entries_due.size();
    if (mat_on) begin
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          if (centre_rule) begin
            e.value = area_scale(64'(d.coef0), prod, sh + 2);
          end else begin
            acc = '0;
            for (int g = 0; g < 4; g++) begin
              w = shape_q(a, g) * shape_q(b, g);
              w = (w + (64'd1 << (FRAC - 1))) >> FRAC;
              wt = {66'd0, w};
              acc = acc + 130'(cf[g]) * wt;
            end
            s = 64'(round_shift(acc, FRAC));
            e.value = area_scale(s, prod, sh);
          end
          e.kind = KIND_MAT; e.row = 2'(a); e.col = 2'(b); e.last = 1'b0;
          entries_due = {entries_due, e};
        end
      end
    end
    if (vec_on) begin
      for (int a = 0; a < 4; a++) begin
        if (centre_rule) begin
          e.value = area_scale(64'(d.load0), prod, sh);
        end else begin
          acc = '0;
          for (int g = 0; g < 4; g++) begin
            wt = {66'd0, shape_q(a, g)};
            acc = acc + 130'(ld[g]) * wt;
          end
          s = 64'(round_shift(acc, FRAC));
          e.value = area_scale(s, prod, sh);
        end
        e.kind = KIND_LOAD; e.row = 2'(a); e.col = 2'd0; e.last = 1'b0;
        entries_due = {entries_due, e};
      end
    end
    if (entries_due.size() > first) entries_due[$].last = 1'b1;
  endtask

  // apb register write, setup then access
  task automatic reg_write(input reg_idx_t idx, input logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    case (idx)
      REG_EDGE_X:  len_x = v;
      REG_EDGE_Y:  len_y = v;
      REG_EDGE_Z:  len_z = v;
      REG_COEF_PP: coef_pp = v[0];
      REG_LOAD_PP: load_pp = v[0];
      REG_REDUCED: centre_rule = v[0];
      REG_MAT_EN:  mat_on = v[0];
      default:     vec_on = v[0];
    endcase
  endtask

  // wait for every expected entry, then let the pipeline go quiet
  task automatic wait_drained();
    while (entries_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one element transfer; valid stays up when there is no gap
  task automatic send_face(input in_data_t d, input int gap);
    bit taken;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    face_entries(d);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 3))
      0:       return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: return $urandom;
    endcase
  endfunction

  // receiver with random stalls
  initial begin
    bit got;
    int g;
    out_ready = 1'b0;
    forever begin
      g = rx_no_stall ? 0 : $urandom_range(0, 12);
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        got = out_valid;
        @(posedge clk);
      end while (!got);
    end
  end

  // result check on each transfer
  always @(negedge clk) begin
    out_data_t x;
    if (rst_n && out_valid && out_ready) begin
      if (entries_due.size() == 0) begin
        $error("unexpected result kind=%0d row=%0d col=%0d value=%0d",
               out_data.kind, out_data.row, out_data.col, out_data.value);
        fail_count++;
      end else begin
        x = entries_due.pop_front();
        if (out_data.kind !== x.kind) begin
          $error("kind: expected %0d, got %0d", x.kind, out_data.kind); fail_count++;
        end
        if (out_data.row !== x.row) begin
          $error("row: expected %0d, got %0d", x.row, out_data.row); fail_count++;
        end
        if (out_data.col !== x.col) begin
          $error("col: expected %0d, got %0d", x.col, out_data.col); fail_count++;
        end
        if (out_data.value !== x.value) begin
          $error("value: expected %0d, got %0d", x.value, out_data.value); fail_count++;
        end
        if (out_data.last !== x.last) begin
          $error("last: expected %0d, got %0d", x.last, out_data.last); fail_count++;
        end
      end
    end
  end

  typedef struct {
    in_data_t d;
    bit       all_zero;
  } face_row_t;

  // stimulus
  initial begin
    face_row_t  rows[NUM_ROWS];
    in_data_t   d;
    logic [4:0] flags[NUM_PHASES];
    logic [31:0] ex, ey, ez;
    int         gap;
    bit         tx_no_stall;

    cycle_count = 0; fail_count = 0; rx_no_stall = 1'b0;
    rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; in_valid = 1'b0; in_data = '0;
    len_x = 32'h0001_0000; len_y = 32'h0001_0000; len_z = 32'h0001_0000;
    coef_pp = 1'b1; load_pp = 1'b1; centre_rule = 1'b0; mat_on = 1'b1; vec_on = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed elements under reset settings
    rows = '{
      '{'{3'd0, 5'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1},
      '{'{3'd7, 5'd31, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1},
      '{'{3'd0, 5'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b0},
      '{'{3'd1, 5'd0, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000,
          -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000, -32'sh8000_0000}, 1'b0},
      '{'{3'd2, 5'd1, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000,
          32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000}, 1'b0},
      '{'{3'd3, 5'd2, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
          32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000}, 1'b0},
      '{'{3'd4, 5'd19, 32'sh7FFF_FFFF, 32'sh0, -32'sh8000_0000, 32'sh1,
          32'sh1, -32'sh1, 32'sh7FFF_FFFF, -32'sh8000_0000}, 1'b0},
      '{'{3'd5, 5'd20, 32'sh7FFF_FFFF, 32'sh0, -32'sh8000_0000, 32'sh1,
          32'sh1, -32'sh1, 32'sh7FFF_FFFF, -32'sh8000_0000}, 1'b0},
      '{'{3'd6, 5'd31, 32'sh0123_4567, 32'sh89AB_CDEF, 32'sh5555_5555, 32'shAAAA_AAAA,
          32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh3333_3333, 32'shCCCC_CCCC}, 1'b0},
      '{'{3'd7, 5'd3, 32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000,
          -32'sh0000_8000, -32'sh0000_8000, -32'sh0000_8000, -32'sh0000_8000}, 1'b0},
      '{'{3'd0, 5'd10, 32'sh1, 32'sh1, 32'sh1, 32'sh1, -32'sh1, -32'sh1, -32'sh1, -32'sh1},
        1'b0}
    };
    foreach (rows[i]) begin
      send_face(rows[i].d, (i % 3 == 0) ? 0 : $urandom_range(1, 12));
      if (rows[i].all_zero) begin
        for (int k = entries_due.size() - 1; k >= 0 && (k == entries_due.size() - 1
             || !entries_due[k].last); k--)
          entries_due[k].value = 64'sd0;
      end
    end
    in_valid <= 1'b0;
    wait_drained();

    // flag settings per phase: {coef_pp, load_pp, centre_rule, mat_on, vec_on}
    flags = '{5'b11011, 5'b00111, 5'b11100, 5'b01011, 5'b10111,
              5'b00011, 5'b11010, 5'b01001, 5'b10110, 5'b11011};

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // edge lengths: extremes in the first phases, then a mix
      case (ph)
        0: begin ex = 32'hFFFF_FFFF; ey = 32'hFFFF_FFFF; ez = 32'hFFFF_FFFF; end
        1: begin ex = 32'h0;         ey = 32'h0;         ez = 32'h0;         end
        2: begin ex = 32'h0000_0001; ey = 32'hFFFF_FFFF; ez = 32'h0001_0000; end
        default: begin
          ex = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
          ey = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
          ez = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
        end
      endcase
      reg_write(REG_EDGE_X, ex);
      reg_write(REG_EDGE_Y, ey);
      reg_write(REG_EDGE_Z, ez);
      reg_write(REG_COEF_PP, {31'd0, flags[ph][4]});
      reg_write(REG_LOAD_PP, {31'd0, flags[ph][3]});
      reg_write(REG_REDUCED, {31'd0, flags[ph][2]});
      reg_write(REG_MAT_EN,  {31'd0, flags[ph][1]});
      reg_write(REG_VEC_EN,  {31'd0, flags[ph][0]});
      @(posedge clk);

      tx_no_stall = (ph % 4 == 1);
      rx_no_stall = (ph % 4 == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        d.face  = 3'($urandom_range(0, 7));
        d.level = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(20, 31))
                                              : 5'($urandom_range(0, 19));
        d.coef0 = rand_q16(); d.coef1 = rand_q16(); d.coef2 = rand_q16(); d.coef3 = rand_q16();
        d.load0 = rand_q16(); d.load1 = rand_q16(); d.load2 = rand_q16(); d.load3 = rand_q16();
        gap = tx_no_stall ? 0 : $urandom_range(0, 12);
        // hold off mid-phase until the output side has caught up
        if (ph == 3 && i == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          while (entries_due.size() != 0) @(posedge clk);
          gap = 0;
        end
        send_face(d, gap);
      end
      in_valid <= 1'b0;
      rx_no_stall = 1'b0;
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
